// ===== hw/rtl/aes_pkg.sv =====
//------------------------------------------------------------------------------
// AES package
// Shared types, register indexes, S-box tables and GF(2^8) helpers.
//------------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned RkDepth = 60;
    localparam int unsigned RkAw    = 6;

    typedef enum logic [2:0] {
        CFG_KEY_SIZE = 3'd0,
        CFG_KEY_W0   = 3'd1,
        CFG_KEY_W1   = 3'd2,
        CFG_KEY_W2   = 3'd3,
        CFG_KEY_W3   = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [3:0] nk;
        logic [3:0] nr;
    } t_size;

    function automatic t_size size_info(input logic [1:0] ks);
        t_size s;
        case (ks)
            2'd0:    begin s.nk = 4'd4; s.nr = 4'd10; end
            2'd1:    begin s.nk = 4'd6; s.nr = 4'd12; end
            default: begin s.nk = 4'd8; s.nr = 4'd14; end
        endcase
        return s;
    endfunction

    localparam logic [7:0] SBOX_FWD [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] SBOX_INV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
    endfunction

endpackage

// ===== hw/rtl/aes_if.sv =====
//------------------------------------------------------------------------------
// AES channel interfaces
// Valid/ready channels for blocks, results and register writes.
//------------------------------------------------------------------------------
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    logic [4:0]  valid_bytes;
    modport source (output valid, action, data_hi, data_lo, valid_bytes, input ready);
    modport sink   (input valid, action, data_hi, data_lo, valid_bytes, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    modport source (output valid, result_hi, result_lo, input ready);
    modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

interface aes_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/aes_round.sv =====
//------------------------------------------------------------------------------
// AES round unit
// One forward or inverse round of the 128-bit state per call, combinational.
//------------------------------------------------------------------------------
module aes_round (
    input  logic         i_inv,
    input  logic         i_mix,
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    output logic [127:0] o_state
);

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] a [16];
    logic [7:0] k2 [4], k4 [4], k8 [4];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = i_state[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c + r] = aes_pkg::SBOX_FWD[s[4*((c + r) & 3) + r]];
            end
        end
        // forward: shift/sub then mix then key; inverse: key then mix then shift/sub
        for (int i = 0; i < 16; i++) begin
            a[i] = (i_inv ? s[i] : t[i]) ^ (i_inv ? i_key[127 - 8*i -: 8] : 8'h00);
        end
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                k2[k] = aes_pkg::xtime(a[4*c + k]);
                k4[k] = aes_pkg::xtime(k2[k]);
                k8[k] = aes_pkg::xtime(k4[k]);
            end
            for (int r = 0; r < 4; r++) begin
                m[4*c + r] = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    case ((k - r) & 3)
                        0: m[4*c + r] ^= i_inv ? (k8[k] ^ k4[k] ^ k2[k]) : k2[k];
                        1: m[4*c + r] ^= i_inv ? (k8[k] ^ k2[k] ^ a[4*c + k])
                                                : (k2[k] ^ a[4*c + k]);
                        2: m[4*c + r] ^= i_inv ? (k8[k] ^ k4[k] ^ a[4*c + k])
                                                : a[4*c + k];
                        default: m[4*c + r] ^= i_inv ? (k8[k] ^ a[4*c + k]) : a[4*c + k];
                    endcase
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (!i_mix) m[i] = a[i];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (i_inv) begin
                    o_state[127 - 8*(4*((c + r) & 3) + r) -: 8] =
                        aes_pkg::SBOX_INV[m[4*c + r]];
                end else begin
                    o_state[127 - 8*(4*c + r) -: 8] = m[4*c + r] ^ i_key[127 - 8*(4*c + r) -: 8];
                end
            end
        end
    end

endmodule

// ===== hw/rtl/aes_block_cipher.sv =====
//------------------------------------------------------------------------------
// AES block cipher
// ECB AES-128/192/256, one shared round unit under a small sequencer.
//------------------------------------------------------------------------------
// Channels: cfg (register writes, index 0 key size, 1..4 key words), in (one
// block with action and valid byte count), out (one 16-byte result).
// Encryption zeroes block bytes at or past valid_bytes; decryption uses all 16.
// After any register write the next block first expands the key schedule into
// a 64-word round-key RAM, one word per cycle; the first round key is read into
// a register as the expansion ends.
// Each block then steps through a load state and one round state per round,
// the round-key RAM giving four words per round through four banks; the result
// is registered as the last round ends and held in the done state.
// in.ready is high only in idle with no register write offered; cfg.ready is
// high only in idle.
// The result stays in its output register until out.ready takes it; the block
// stays busy until then.
// Reset (synchronous, active low) sets key size 256, keys zero, schedule stale.
//------------------------------------------------------------------------------
module aes_block_cipher (
    input  logic     i_clk,
    input  logic     i_rst_n,
    aes_cfg_if.sink  cfg,
    aes_in_if.sink   in,
    aes_out_if.source out
);

    aes_pkg::t_state r_state, n_state;
    logic [1:0]   r_ksize;
    logic [63:0]  r_kw [4];
    logic         r_keys_ready;
    logic         r_inv;
    logic [127:0] r_blk;
    logic [5:0]   r_widx;
    logic [3:0]   r_rnd;
    logic [31:0]  r_w1, r_w2, r_w3, r_w4, r_w5, r_w6, r_w7, r_w8;
    logic [7:0]   r_rcon;
    logic [3:0]   r_mod;
    logic         r_out_valid;
    logic [127:0] r_res;

    logic [31:0]  r_bank0 [16];
    logic [31:0]  r_bank1 [16];
    logic [31:0]  r_bank2 [16];
    logic [31:0]  r_bank3 [16];
    logic [127:0] r_key_q;

    aes_pkg::t_size sz;
    logic [31:0]  w_new, w_t, w_nk;
    logic [3:0]   rd_rnd;
    logic [127:0] round_out;
    logic         cfg_fire, in_fire;
    logic [127:0] in_blk;
    logic [127:0] masked;

    assign sz       = aes_pkg::size_info(r_ksize);
    assign cfg_fire = cfg.valid && cfg.ready;
    assign in_fire  = in.valid && in.ready;
    assign cfg.ready = (r_state == aes_pkg::ST_IDLE);
    assign in.ready  = (r_state == aes_pkg::ST_IDLE) && !cfg.valid;
    assign out.valid = r_out_valid;
    assign out.result_hi = r_res[127:64];
    assign out.result_lo = r_res[63:0];
    assign in_blk   = {in.data_hi, in.data_lo};

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            masked[127 - 8*i -: 8] = (in.action || (5'(i) < in.valid_bytes))
                ? in_blk[127 - 8*i -: 8] : 8'h00;
        end
    end

    // key expansion word: shift window holds the last eight words, w_nk the oldest of the last Nk
    always_comb begin
        case (sz.nk)
            4'd4:    w_nk = r_w4;
            4'd6:    w_nk = r_w6;
            default: w_nk = r_w8;
        endcase
        w_t = r_w1;
        if (r_mod == 4'd0) begin
            w_t = aes_pkg::sub_word({r_w1[23:0], r_w1[31:24]}) ^ {r_rcon, 24'h0};
        end else if (sz.nk == 4'd8 && r_mod == 4'd4) begin
            w_t = aes_pkg::sub_word(r_w1);
        end
        if (r_widx < 6'(sz.nk)) begin
            case (r_widx[2:0])
                3'd0: w_new = r_kw[0][63:32];
                3'd1: w_new = r_kw[0][31:0];
                3'd2: w_new = r_kw[1][63:32];
                3'd3: w_new = r_kw[1][31:0];
                3'd4: w_new = r_kw[2][63:32];
                3'd5: w_new = r_kw[2][31:0];
                3'd6: w_new = r_kw[3][63:32];
                default: w_new = r_kw[3][31:0];
            endcase
        end else begin
            w_new = w_nk ^ w_t;
        end
    end

    // round-key read: first round number in idle, next round number in load and round
    always_comb begin
        rd_rnd = r_rnd;
        if (r_state == aes_pkg::ST_LOAD || r_state == aes_pkg::ST_ROUND) begin
            rd_rnd = r_inv ? r_rnd - 4'd1 : r_rnd + 4'd1;
        end
        if (r_state == aes_pkg::ST_IDLE) begin
            rd_rnd = in.action ? sz.nr : 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == aes_pkg::ST_EXPAND) begin
            case (r_widx[1:0])
                2'd0: r_bank0[r_widx[5:2]] <= w_new;
                2'd1: r_bank1[r_widx[5:2]] <= w_new;
                2'd2: r_bank2[r_widx[5:2]] <= w_new;
                default: r_bank3[r_widx[5:2]] <= w_new;
            endcase
        end
        r_key_q <= {r_bank0[rd_rnd], r_bank1[rd_rnd], r_bank2[rd_rnd], r_bank3[rd_rnd]};
    end

    aes_round u_round (
        .i_inv   (r_inv),
        .i_mix   (r_inv ? (r_state != aes_pkg::ST_LOAD) : (r_rnd != sz.nr)),
        .i_state (r_blk),
        .i_key   (r_key_q),
        .o_state (round_out)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            aes_pkg::ST_IDLE:
                if (in_fire) n_state = r_keys_ready ? aes_pkg::ST_LOAD : aes_pkg::ST_EXPAND;
            aes_pkg::ST_EXPAND:
                if (r_widx == 6'(4 * (sz.nr + 4'd1))) n_state = aes_pkg::ST_LOAD;
            aes_pkg::ST_LOAD:
                n_state = aes_pkg::ST_ROUND;
            aes_pkg::ST_ROUND:
                if (r_inv ? (r_rnd == 4'd0) : (r_rnd == sz.nr)) n_state = aes_pkg::ST_DONE;
            aes_pkg::ST_DONE:
                if (out.ready) n_state = aes_pkg::ST_IDLE;
            default:
                n_state = aes_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= aes_pkg::ST_IDLE;
            r_ksize      <= 2'd2;
            r_kw         <= '{default: 64'h0};
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_fire) begin
                case (cfg.index)
                    aes_pkg::CFG_KEY_SIZE: begin
                        r_ksize <= cfg.data[1:0]; r_keys_ready <= 1'b0;
                    end
                    aes_pkg::CFG_KEY_W0: begin r_kw[0] <= cfg.data; r_keys_ready <= 1'b0; end
                    aes_pkg::CFG_KEY_W1: begin r_kw[1] <= cfg.data; r_keys_ready <= 1'b0; end
                    aes_pkg::CFG_KEY_W2: begin r_kw[2] <= cfg.data; r_keys_ready <= 1'b0; end
                    aes_pkg::CFG_KEY_W3: begin r_kw[3] <= cfg.data; r_keys_ready <= 1'b0; end
                    default: ;
                endcase
            end
            if (r_state == aes_pkg::ST_EXPAND && n_state == aes_pkg::ST_LOAD) begin
                r_keys_ready <= 1'b1;
            end
            if (r_state == aes_pkg::ST_ROUND && n_state == aes_pkg::ST_DONE) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            aes_pkg::ST_IDLE: begin
                r_inv  <= in.action;
                r_blk  <= masked;
                r_rnd  <= in.action ? sz.nr : 4'd0;
                r_widx <= 6'd0;
                r_mod  <= 4'd0;
                r_rcon <= 8'h01;
            end
            aes_pkg::ST_EXPAND: begin
                {r_w8, r_w7, r_w6, r_w5, r_w4, r_w3, r_w2, r_w1} <=
                    {r_w7, r_w6, r_w5, r_w4, r_w3, r_w2, r_w1, w_new};
                r_widx <= r_widx + 6'd1;
                r_mod  <= (r_mod == sz.nk - 4'd1) ? 4'd0 : r_mod + 4'd1;
                if (r_widx >= 6'(sz.nk) && r_mod == 4'd0) r_rcon <= aes_pkg::xtime(r_rcon);
            end
            aes_pkg::ST_LOAD: begin
                r_blk <= r_inv ? round_out : (r_blk ^ r_key_q);
                r_rnd <= r_inv ? r_rnd - 4'd1 : r_rnd + 4'd1;
            end
            aes_pkg::ST_ROUND: begin
                r_blk <= round_out;
                r_rnd <= r_inv ? r_rnd - 4'd1 : r_rnd + 4'd1;
                if (n_state == aes_pkg::ST_DONE) r_res <= r_inv ? (r_blk ^ r_key_q)
                                                               : round_out;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_out_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == aes_pkg::ST_DONE))
        else $error("result valid outside done state");
    a_keys_before_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_pkg::ST_LOAD) |-> r_keys_ready)
        else $error("block started with stale key schedule");
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out.valid && out.ready) |=> (r_state == aes_pkg::ST_IDLE))
        else $error("no return to idle after result taken");
`endif

endmodule
